[hw/rtl/v3n_pkg.sv]
// Shared constants and types for the vector normalizer.
package v3n_pkg;

    localparam int COMP_W      = 32;
    localparam int MAG_W       = 32;
    localparam int UNIT_W      = 18;
    localparam int THR_W       = 16;
    localparam int FRAC_BITS_D = 16;

    // Payload that travels along the square-root chain.
    typedef struct packed {
        logic             valid;
        logic [63:0]      rem;
        logic [MAG_W-1:0] root;
        logic [31:0]      ax;
        logic [31:0]      ay;
        logic [31:0]      az;
        logic             nx;
        logic             ny;
        logic             nz;
        logic [THR_W-1:0] thr;
    } v3n_sq_t;

endpackage

[hw/rtl/v3n_sqrt_cell.sv]
// One restoring square-root step: settles one bit of the magnitude.
module v3n_sqrt_cell
#(
    parameter int STEP = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  v3n_pkg::v3n_sq_t  din,
    output v3n_pkg::v3n_sq_t  dout
);
    import v3n_pkg::*;

    localparam int SH = 2 * (MAG_W - 1 - STEP);

    logic [63:0]      trial;
    logic [63:0]      shifted;
    logic [MAG_W-1:0] bitv;
    logic             valid_reg;
    v3n_sq_t          dout_reg;
    v3n_sq_t          dout_next;

    always_comb
    begin
        bitv    = '0;
        bitv[MAG_W-1-STEP] = 1'b1;
        // Candidate (2*root + bit) * bit, aligned at this step's weight.
        trial   = ({32'b0, din.root} << (MAG_W - STEP)) | (64'd1 << SH);
        shifted = trial;
        dout_next = din;
        if (din.rem >= shifted)
        begin
            dout_next.rem  = din.rem - shifted;
            dout_next.root = din.root | bitv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= din.valid;
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    always_comb
    begin
        dout       = dout_reg;
        dout.valid = valid_reg;
    end
endmodule

[hw/rtl/v3n_div_cell.sv]
// One restoring division step for all three components at once.
module v3n_div_cell
#(
    parameter int QW = 18
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             vin,
    input  logic [31:0]      din_mag,
    input  logic [31:0]      din_num [3],
    input  logic [QW-1:0]    din_q   [3],
    input  logic [32:0]      din_rem [3],
    input  logic [2:0]       din_neg,
    input  logic             din_deg,
    output logic             vout,
    output logic [31:0]      dout_mag,
    output logic [31:0]      dout_num [3],
    output logic [QW-1:0]    dout_q   [3],
    output logic [32:0]      dout_rem [3],
    output logic [2:0]       dout_neg,
    output logic             dout_deg
);
    logic [33:0]   trial [3];
    logic [QW-1:0] q_next [3];
    logic [32:0]   r_next [3];
    logic          vout_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            // Bring in the next numerator bit (MSB first).
            trial[i] = {din_rem[i], din_num[i][31]};
            if (trial[i] >= {2'b0, din_mag})
            begin
                r_next[i] = 33'(trial[i] - {2'b0, din_mag});
                q_next[i] = {din_q[i][QW-2:0], 1'b1};
            end
            else
            begin
                r_next[i] = trial[i][32:0];
                q_next[i] = {din_q[i][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vout_reg <= 1'b0;
        else
            vout_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            dout_q[i]   <= q_next[i];
            dout_rem[i] <= r_next[i];
            dout_num[i] <= {din_num[i][30:0], 1'b0};
        end
        dout_mag <= din_mag;
        dout_neg <= din_neg;
        dout_deg <= din_deg;
    end

    assign vout = vout_reg;
endmodule

[hw/rtl/vector3_normalize.sv]
// Top level of the pipelined three-component vector normalizer.
//  channel   | ports                                   | handshake
//  request   | comp_x, comp_y, comp_z                  | start (busy stays low)
//  result    | unit_x, unit_y, unit_z, degenerate      | done, one cycle
//  config    | cfg_data                                | cfg_we
// One request per cycle. One stage forms squares, 32 root cells settle the
// magnitude one bit each, one divider cell per numerator bit forms the three
// quotients in parallel, and an output register holds the result.
// Reset clears all valid flags and the threshold. The receiver cannot stall,
// so busy is tied low.
module vector3_normalize
#(
    parameter int FRAC_BITS = v3n_pkg::FRAC_BITS_D
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [31:0]           comp_x,
    input  logic signed [31:0]           comp_y,
    input  logic signed [31:0]           comp_z,
    input  logic                         cfg_we,
    input  logic [v3n_pkg::THR_W-1:0]    cfg_data,
    output logic                         done,
    output logic signed [17:0]           unit_x,
    output logic signed [17:0]           unit_y,
    output logic signed [17:0]           unit_z,
    output logic                         degenerate
);
    import v3n_pkg::*;

    localparam int NB = 32 + FRAC_BITS;
    localparam int QW = FRAC_BITS + 2;

    logic [THR_W-1:0] thr_reg;
    v3n_sq_t          sq [MAG_W+1];
    logic [31:0]      a_in [3];
    logic [2:0]       n_in;
    logic [63:0]      p_reg [3];
    logic [63:0]      sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= '0;
        else if (cfg_we)
            thr_reg <= cfg_data;
    end

    assign busy = 1'b0;

    always_comb
    begin
        n_in    = {comp_z[31], comp_y[31], comp_x[31]};
        a_in[0] = comp_x[31] ? 32'(-comp_x) : comp_x;
        a_in[1] = comp_y[31] ? 32'(-comp_y) : comp_y;
        a_in[2] = comp_z[31] ? 32'(-comp_z) : comp_z;
    end

    // Square stage.
    logic        v0_reg;
    logic [31:0] a0_reg [3];
    logic [2:0]  n0_reg;
    logic [THR_W-1:0] t0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_reg[i]  <= 64'(a_in[i]) * 64'(a_in[i]);
            a0_reg[i] <= a_in[i];
        end
        n0_reg <= n_in;
        t0_reg <= thr_reg;
    end

    assign sum = p_reg[0] + p_reg[1] + p_reg[2];

    always_comb
    begin
        sq[0].valid = v0_reg;
        sq[0].rem   = sum;
        sq[0].root  = '0;
        sq[0].ax    = a0_reg[0];
        sq[0].ay    = a0_reg[1];
        sq[0].az    = a0_reg[2];
        sq[0].nx    = n0_reg[0];
        sq[0].ny    = n0_reg[1];
        sq[0].nz    = n0_reg[2];
        sq[0].thr   = t0_reg;
    end

    for (genvar s = 0; s < MAG_W; s++)
    begin : g_sqrt
        v3n_sqrt_cell #(.STEP(s)) u_cell
        (
            .clk  (clk),
            .rst_n(rst_n),
            .din  (sq[s]),
            .dout (sq[s+1])
        );
    end

    // Division chain; numerator is |c| << FRAC_BITS, fed MSB first.
    logic          dv   [NB+1];
    logic [31:0]   dmag [NB+1];
    logic [31:0]   dnum [NB+1][3];
    logic [QW-1:0] dq   [NB+1][3];
    logic [32:0]   drem [NB+1][3];
    logic [2:0]    dneg [NB+1];
    logic          ddeg [NB+1];

    always_comb
    begin
        dv[0]      = sq[MAG_W].valid;
        ddeg[0]    = !(sq[MAG_W].root > {16'b0, sq[MAG_W].thr});
        dmag[0]    = ddeg[0] ? 32'd1 : sq[MAG_W].root;
        dnum[0][0] = sq[MAG_W].ax;
        dnum[0][1] = sq[MAG_W].ay;
        dnum[0][2] = sq[MAG_W].az;
        dneg[0]    = {sq[MAG_W].nz, sq[MAG_W].ny, sq[MAG_W].nx};
        for (int i = 0; i < 3; i++)
        begin
            dq[0][i]   = '0;
            drem[0][i] = '0;
        end
    end

    for (genvar k = 0; k < NB; k++)
    begin : g_div
        v3n_div_cell #(.QW(QW)) u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .vin     (dv[k]),
            .din_mag (dmag[k]),
            .din_num (dnum[k]),
            .din_q   (dq[k]),
            .din_rem (drem[k]),
            .din_neg (dneg[k]),
            .din_deg (ddeg[k]),
            .vout    (dv[k+1]),
            .dout_mag(dmag[k+1]),
            .dout_num(dnum[k+1]),
            .dout_q  (dq[k+1]),
            .dout_rem(drem[k+1]),
            .dout_neg(dneg[k+1]),
            .dout_deg(ddeg[k+1])
        );
    end

    // Output register with sign restore, wrap to the field width and zero on degenerate.
    logic             done_reg;
    logic [UNIT_W-1:0] u_reg [3];
    logic             deg_reg;
    logic [UNIT_W-1:0] u_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_next[i] = UNIT_W'(dq[NB][i]);
            if (dneg[NB][i])
                u_next[i] = UNIT_W'(-u_next[i]);
            if (ddeg[NB])
                u_next[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv[NB];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            u_reg[i] <= u_next[i];
        deg_reg <= ddeg[NB];
    end

    assign done       = done_reg;
    assign unit_x     = u_reg[0];
    assign unit_y     = u_reg[1];
    assign unit_z     = u_reg[2];
    assign degenerate = deg_reg;
endmodule
